// ===== sv/tapvc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Two-axis PID velocity controller: shared definitions
// Payload types, register indexes, controller states and commands, and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tapvc_pkg;

	localparam int VELOCITY_WIDTH = 16;
	localparam int ANGLE_WIDTH    = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [15:0] DT_DEFAULT = 16'd66;

	// Shared divider sizes.
	localparam int DIV_DVD_W = 48;
	localparam int DIV_DVS_W = 32;
	localparam int DIV_SH_W  = 50;
	localparam int DIV_Q_W   = 34;
	localparam int DIV_IDX_W = 6;

	localparam int CORDIC_STEPS = 20;
	localparam int CNT_W        = 5;
	localparam logic signed [30:0] CORDIC_INV_GAIN = 31'sd39797;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN   = 3'd0,
		CFG_INTEG_GAIN  = 3'd1,
		CFG_DERIV_GAIN  = 3'd2,
		CFG_INTEG_LIMIT = 3'd3,
		CFG_SPEED_LIMIT = 3'd4,
		CFG_STEP_PERIOD = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [VELOCITY_WIDTH-1:0] target_vx;
		logic signed [VELOCITY_WIDTH-1:0] target_vy;
		logic signed [VELOCITY_WIDTH-1:0] measured_vx;
		logic signed [VELOCITY_WIDTH-1:0] measured_vy;
		logic [ANGLE_WIDTH-1:0]           heading;
		logic                             clear_loop;
	} in_req_t;

	typedef struct packed {
		logic signed [VELOCITY_WIDTH-1:0] command_vx;
		logic signed [VELOCITY_WIDTH-1:0] command_vy;
		logic                             limited;
	} out_req_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ERR, ST_MUL_EDT, ST_INTEG, ST_DIV_WAIT, ST_MUL_P, ST_MUL_I,
		ST_MUL_D, ST_ACC_D, ST_PID_OUT, ST_SHRINK, ST_SQ_L, ST_SQ_X, ST_SQ_Y,
		ST_MAG, ST_CMP, ST_SQRT, ST_RS_MUL, ST_RS_DIV, ST_RS_WAIT, ST_ROT_INIT,
		ST_CORDIC, ST_FIN_X, ST_FIN_Y, ST_FIN_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_ERR, OP_MUL_EDT, OP_INTEG, OP_DIV_WAIT, OP_MUL_P,
		OP_MUL_I, OP_MUL_D, OP_ACC_D, OP_PID_OUT, OP_SHRINK, OP_SQ_L, OP_SQ_X,
		OP_SQ_Y, OP_MAG, OP_CMP, OP_SQRT, OP_RS_MUL, OP_RS_DIV, OP_RS_WAIT,
		OP_ROT_INIT, OP_CORDIC, OP_FIN_X, OP_FIN_Y, OP_FIN_OUT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             axis;
		logic [CNT_W-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic big;
		logic over;
	} sts_t;

	// Arctangent of 2^-i in units of 2^32 per turn.
	function automatic logic [31:0] atan_entry(input logic [CNT_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:    v = 32'h20000000;
			5'd1:    v = 32'h12E4051E;
			5'd2:    v = 32'h09FB385B;
			5'd3:    v = 32'h051111D4;
			5'd4:    v = 32'h028B0D43;
			5'd5:    v = 32'h0145D7E1;
			5'd6:    v = 32'h00A2F61E;
			5'd7:    v = 32'h00517C55;
			5'd8:    v = 32'h0028BE53;
			5'd9:    v = 32'h00145F2F;
			5'd10:   v = 32'h000A2F98;
			5'd11:   v = 32'h000517CC;
			5'd12:   v = 32'h00028BE6;
			5'd13:   v = 32'h000145F3;
			5'd14:   v = 32'h0000A2FA;
			5'd15:   v = 32'h0000517D;
			5'd16:   v = 32'h000028BE;
			5'd17:   v = 32'h0000145F;
			5'd18:   v = 32'h00000A30;
			5'd19:   v = 32'h00000518;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== sv/tapvc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned shift-and-subtract divider, one quotient bit per cycle, starting
// at a given quotient bit index.
// ----------------------------------------------------------------------------
module tapvc_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [tapvc_pkg::DIV_DVD_W-1:0] dividend,
	input  wire logic [tapvc_pkg::DIV_DVS_W-1:0] divisor,
	input  wire logic [tapvc_pkg::DIV_IDX_W-1:0] idx,
	output logic                                 done,
	output logic [tapvc_pkg::DIV_Q_W-1:0]        quot
);
	import tapvc_pkg::*;

	logic                 busy_q, done_q;
	logic [DIV_DVD_W-1:0] rem_q;
	logic [DIV_SH_W-1:0]  dsh_q;
	logic [DIV_Q_W-1:0]   q_q;
	logic [DIV_IDX_W-1:0] cnt_q;
	logic                 ge;

	assign ge   = {{(DIV_SH_W-DIV_DVD_W){1'b0}}, rem_q} >= dsh_q;
	assign done = done_q;
	assign quot = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= idx;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= DIV_SH_W'(divisor) << idx;
			q_q   <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[DIV_DVD_W-1:0];
			end
			q_q   <= {q_q[DIV_Q_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule
`default_nettype wire

// ===== sv/tapvc_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Controller datapath
// Configuration registers, loop state, shared multiplier, square root step,
// CORDIC step and output register, driven by commands from the controller.
// ----------------------------------------------------------------------------
module tapvc_dpath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tapvc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [tapvc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire tapvc_pkg::in_req_t              in_req,
	input  wire tapvc_pkg::cmd_t                 cmd,
	output tapvc_pkg::sts_t                      sts,
	output tapvc_pkg::out_req_t                  out_req
);
	import tapvc_pkg::*;

	localparam int VW = VELOCITY_WIDTH;
	localparam int E_W = VW + 1;
	localparam int O_W = 44;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;
	localparam logic signed [63:0] VMAX = (64'sd1 <<< (VW - 1)) - 64'sd1;
	localparam logic signed [63:0] VMIN = -(64'sd1 <<< (VW - 1));
	localparam logic signed [O_W-1:0] BIG = O_W'(64'sd1 <<< 30);

	// Configuration.
	logic [15:0] prop_gain_q, integ_gain_q, deriv_gain_q, step_period_q;
	logic [14:0] integ_limit_q, speed_limit_q;

	// Loop state.
	logic signed [15:0]  integ_q [2];
	logic signed [E_W-1:0] prev_q [2];

	// Working registers.
	in_req_t              in_q;
	logic [15:0]          dt_q;
	logic signed [E_W-1:0] e_q;
	logic signed [E_W:0]   ed_q;
	logic signed [15:0]   i_q;
	logic signed [34:0]   d_q;
	logic signed [63:0]   prod_q, acc_q;
	logic signed [O_W-1:0] ox_q, oy_q;
	logic [29:0]          lim2_q;
	logic [61:0]          mag2_q, sq_r_q;
	logic                 limited_q, div_neg_q;
	logic signed [31:0]   x_q, y_q, z_q;
	logic signed [VW-1:0] res_x_q;
	out_req_t             out_q;

	// Combinational.
	logic signed [VW-1:0]  t_sel, m_sel;
	logic signed [E_W-1:0] e_new;
	logic signed [34:0]    ma;
	logic signed [30:0]    mb;
	logic signed [65:0]    prod_n;
	logic signed [33:0]    irnd;
	logic signed [18:0]    isum, ilim;
	logic signed [15:0]    i_new;
	logic [E_W:0]          ed_mag;
	logic signed [63:0]    p_mag;
	logic                  div_start, div_done;
	logic [DIV_DVD_W-1:0]  div_dvd;
	logic [DIV_DVS_W-1:0]  div_dvs;
	logic [DIV_IDX_W-1:0]  div_idx;
	logic [DIV_Q_W-1:0]    div_q;
	logic signed [63:0]    pid;
	logic [61:0]           sq_bit, sq_trial;
	logic signed [31:0]    xs, ys, rx, ry;
	logic [31:0]           ang;
	logic signed [31:0]    atan_v;
	logic [16:0]           k3;

	function automatic logic signed [VW-1:0] round_sat(input logic signed [63:0] p);
		logic signed [63:0] r;
		r = (p + 64'sd134217728) >>> 28;
		if (r > VMAX) begin
			r = VMAX;
		end else if (r < VMIN) begin
			r = VMIN;
		end
		return r[VW-1:0];
	endfunction

	assign t_sel = cmd.axis ? in_q.target_vy : in_q.target_vx;
	assign m_sel = cmd.axis ? in_q.measured_vy : in_q.measured_vx;
	assign e_new = E_W'(t_sel) - E_W'(m_sel);
	assign k3    = 17'(speed_limit_q) * 17'd3;

	// Shared multiplier operand selection.
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_MUL_EDT: begin
				ma = 35'(e_q);
				mb = 31'($signed({1'b0, dt_q}));
			end
			OP_MUL_P: begin
				ma = 35'(e_q);
				mb = 31'($signed({1'b0, prop_gain_q}));
			end
			OP_MUL_I: begin
				ma = 35'(i_q);
				mb = 31'($signed({1'b0, integ_gain_q}));
			end
			OP_MUL_D: begin
				ma = d_q;
				mb = 31'($signed({1'b0, deriv_gain_q}));
			end
			OP_SQ_L: begin
				ma = 35'($signed({1'b0, speed_limit_q}));
				mb = 31'($signed({1'b0, speed_limit_q}));
			end
			OP_SQ_X: begin
				ma = 35'($signed(ox_q[30:0]));
				mb = ox_q[30:0];
			end
			OP_SQ_Y: begin
				ma = 35'($signed(oy_q[30:0]));
				mb = oy_q[30:0];
			end
			OP_RS_MUL: begin
				ma = cmd.axis ? 35'($signed(oy_q[30:0])) : 35'($signed(ox_q[30:0]));
				mb = 31'($signed({1'b0, k3}));
			end
			OP_FIN_X: begin
				ma = 35'(x_q);
				mb = CORDIC_INV_GAIN;
			end
			OP_FIN_Y: begin
				ma = 35'(y_q);
				mb = CORDIC_INV_GAIN;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod_n = 66'(ma) * 66'(mb);

	// Integrator update: round half up, then clamp.
	assign irnd = 34'($signed(prod_q[32:0])) + 34'sd32768;
	assign isum = 19'(integ_q[cmd.axis]) + 19'(irnd >>> 16);
	assign ilim = 19'($signed({1'b0, integ_limit_q}));
	always_comb begin
		if (isum > ilim) begin
			i_new = ilim[15:0];
		end else if (isum < -ilim) begin
			i_new = 16'(-ilim);
		end else begin
			i_new = isum[15:0];
		end
	end

	assign ed_mag = ed_q[E_W] ? (E_W+1)'(-ed_q) : (E_W+1)'(ed_q);
	assign p_mag  = prod_q[63] ? -prod_q : prod_q;

	// Divider requests: derivative, then the two rescale divisions.
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		div_idx   = '0;
		case (cmd.op)
			OP_INTEG: begin
				div_start = 1'b1;
				div_dvd   = DIV_DVD_W'(ed_mag) << 16;
				div_dvs   = DIV_DVS_W'(dt_q);
				div_idx   = DIV_IDX_W'(33);
			end
			OP_RS_DIV: begin
				div_start = 1'b1;
				div_dvd   = p_mag[DIV_DVD_W-1:0];
				div_dvs   = {sq_r_q[30:0], 1'b0};
				div_idx   = DIV_IDX_W'(15);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	tapvc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.idx      (div_idx),
		.done     (div_done),
		.quot     (div_q)
	);

	assign pid = (acc_q + 64'sd128) >>> 8;

	// Square root step.
	assign sq_bit   = 62'(1) << {cmd.cnt, 1'b0};
	assign sq_trial = sq_r_q + sq_bit;

	// Quadrant rotation of the guarded vector.
	assign ang = 32'(in_q.heading) << (32 - ANGLE_WIDTH);
	assign xs  = 32'($signed(ox_q[16:0])) <<< 12;
	assign ys  = 32'($signed(oy_q[16:0])) <<< 12;
	always_comb begin
		case (ang[31:30])
			QUAD_1: begin
				rx = -ys;
				ry = xs;
			end
			QUAD_2: begin
				rx = -xs;
				ry = -ys;
			end
			QUAD_3: begin
				rx = ys;
				ry = -xs;
			end
			default: begin
				rx = xs;
				ry = ys;
			end
		endcase
	end
	assign atan_v = $signed(atan_entry(cmd.cnt));

	assign sts.div_done = div_done;
	assign sts.big  = (ox_q >= BIG) || (ox_q <= -BIG) || (oy_q >= BIG) || (oy_q <= -BIG);
	assign sts.over = mag2_q > 62'(lim2_q);
	assign out_req  = out_q;

	// Configuration and loop state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= 16'd256;
			integ_gain_q  <= 16'd0;
			deriv_gain_q  <= 16'd0;
			integ_limit_q <= 15'd4096;
			speed_limit_q <= 15'd12288;
			step_period_q <= 16'd66;
			integ_q[0]    <= '0;
			integ_q[1]    <= '0;
			prev_q[0]     <= '0;
			prev_q[1]     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_PROP_GAIN:   prop_gain_q   <= cfg_data;
					CFG_INTEG_GAIN:  integ_gain_q  <= cfg_data;
					CFG_DERIV_GAIN:  deriv_gain_q  <= cfg_data;
					CFG_INTEG_LIMIT: integ_limit_q <= cfg_data[14:0];
					CFG_SPEED_LIMIT: speed_limit_q <= cfg_data[14:0];
					CFG_STEP_PERIOD: step_period_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.op == OP_LOAD && in_req.clear_loop) begin
				integ_q[0] <= '0;
				integ_q[1] <= '0;
				prev_q[0]  <= '0;
				prev_q[1]  <= '0;
			end
			if (cmd.op == OP_INTEG) begin
				integ_q[cmd.axis] <= i_new;
			end
			if (cmd.op == OP_DIV_WAIT) begin
				prev_q[cmd.axis] <= e_q;
			end
		end
	end

	// Working registers. The product holds while the sequencer idles or waits
	// on the output, so the second rotated component survives a stall.
	always_ff @(posedge clk) begin
		if (cmd.op != OP_NONE) begin
			prod_q <= prod_n[63:0];
		end
		case (cmd.op)
			OP_LOAD: begin
				in_q <= in_req;
				dt_q <= (step_period_q == '0) ? DT_DEFAULT : step_period_q;
			end
			OP_ERR: begin
				e_q  <= e_new;
				ed_q <= (E_W+1)'(e_new) - (E_W+1)'(prev_q[cmd.axis]);
			end
			OP_INTEG: begin
				i_q       <= i_new;
				div_neg_q <= ed_q[E_W];
			end
			OP_DIV_WAIT: begin
				d_q <= div_neg_q ? -35'(div_q) : 35'(div_q);
			end
			OP_MUL_I: begin
				acc_q <= prod_q;
			end
			OP_MUL_D, OP_ACC_D: begin
				acc_q <= acc_q + prod_q;
			end
			OP_PID_OUT: begin
				if (cmd.axis) begin
					oy_q <= O_W'(t_sel) + pid[O_W-1:0];
				end else begin
					ox_q <= O_W'(t_sel) + pid[O_W-1:0];
				end
			end
			OP_SHRINK: begin
				if (sts.big) begin
					ox_q <= ox_q >>> 1;
					oy_q <= oy_q >>> 1;
				end
			end
			OP_SQ_X: begin
				lim2_q <= prod_q[29:0];
			end
			OP_SQ_Y: begin
				acc_q <= prod_q;
			end
			OP_MAG: begin
				mag2_q <= acc_q[61:0] + prod_q[61:0];
			end
			OP_CMP: begin
				limited_q <= sts.over;
				sq_r_q    <= '0;
			end
			OP_SQRT: begin
				if (mag2_q >= sq_trial) begin
					mag2_q <= mag2_q - sq_trial;
					sq_r_q <= (sq_r_q >> 1) + sq_bit;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
			end
			OP_RS_DIV: begin
				div_neg_q <= prod_q[63];
			end
			OP_RS_WAIT: begin
				if (cmd.axis) begin
					oy_q <= div_neg_q ? -O_W'(div_q) : O_W'(div_q);
				end else begin
					ox_q <= div_neg_q ? -O_W'(div_q) : O_W'(div_q);
				end
			end
			OP_ROT_INIT: begin
				x_q <= rx;
				y_q <= ry;
				z_q <= $signed({2'b00, ang[29:0]});
			end
			OP_CORDIC: begin
				if (!z_q[31]) begin
					x_q <= x_q - (y_q >>> cmd.cnt);
					y_q <= y_q + (x_q >>> cmd.cnt);
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + (y_q >>> cmd.cnt);
					y_q <= y_q - (x_q >>> cmd.cnt);
					z_q <= z_q + atan_v;
				end
			end
			OP_FIN_Y: begin
				res_x_q <= round_sat(prod_q);
			end
			OP_FIN_OUT: begin
				out_q.command_vx <= res_x_q;
				out_q.command_vy <= round_sat(prod_q);
				out_q.limited    <= limited_q;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/tapvc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Controller sequencer
// Steps one request through the datapath: per-axis PID, magnitude limit and
// rotation, and holds the request handshakes.
// ----------------------------------------------------------------------------
module tapvc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire tapvc_pkg::sts_t sts,
	output tapvc_pkg::cmd_t      cmd
);
	import tapvc_pkg::*;

	state_t           state_q, state_n;
	logic             axis_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_n = ST_ERR;
			ST_ERR:      state_n = ST_MUL_EDT;
			ST_MUL_EDT:  state_n = ST_INTEG;
			ST_INTEG:    state_n = ST_DIV_WAIT;
			ST_DIV_WAIT: if (sts.div_done) state_n = ST_MUL_P;
			ST_MUL_P:    state_n = ST_MUL_I;
			ST_MUL_I:    state_n = ST_MUL_D;
			ST_MUL_D:    state_n = ST_ACC_D;
			ST_ACC_D:    state_n = ST_PID_OUT;
			ST_PID_OUT:  state_n = axis_q ? ST_SHRINK : ST_ERR;
			ST_SHRINK:   if (!sts.big) state_n = ST_SQ_L;
			ST_SQ_L:     state_n = ST_SQ_X;
			ST_SQ_X:     state_n = ST_SQ_Y;
			ST_SQ_Y:     state_n = ST_MAG;
			ST_MAG:      state_n = ST_CMP;
			ST_CMP:      state_n = sts.over ? ST_SQRT : ST_ROT_INIT;
			ST_SQRT:     if (cnt_q == '0) state_n = ST_RS_MUL;
			ST_RS_MUL:   state_n = ST_RS_DIV;
			ST_RS_DIV:   state_n = ST_RS_WAIT;
			ST_RS_WAIT:  if (sts.div_done) state_n = axis_q ? ST_ROT_INIT : ST_RS_MUL;
			ST_ROT_INIT: state_n = ST_CORDIC;
			ST_CORDIC:   if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) state_n = ST_FIN_X;
			ST_FIN_X:    state_n = ST_FIN_Y;
			ST_FIN_Y:    state_n = ST_FIN_OUT;
			ST_FIN_OUT:  if (out_free) state_n = ST_IDLE;
			default:     state_n = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd.axis = axis_q;
		cmd.cnt  = cnt_q;
		unique case (state_q)
			ST_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NONE;
			ST_ERR:      cmd.op = OP_ERR;
			ST_MUL_EDT:  cmd.op = OP_MUL_EDT;
			ST_INTEG:    cmd.op = OP_INTEG;
			ST_DIV_WAIT: cmd.op = OP_DIV_WAIT;
			ST_MUL_P:    cmd.op = OP_MUL_P;
			ST_MUL_I:    cmd.op = OP_MUL_I;
			ST_MUL_D:    cmd.op = OP_MUL_D;
			ST_ACC_D:    cmd.op = OP_ACC_D;
			ST_PID_OUT:  cmd.op = OP_PID_OUT;
			ST_SHRINK:   cmd.op = OP_SHRINK;
			ST_SQ_L:     cmd.op = OP_SQ_L;
			ST_SQ_X:     cmd.op = OP_SQ_X;
			ST_SQ_Y:     cmd.op = OP_SQ_Y;
			ST_MAG:      cmd.op = OP_MAG;
			ST_CMP:      cmd.op = OP_CMP;
			ST_SQRT:     cmd.op = OP_SQRT;
			ST_RS_MUL:   cmd.op = OP_RS_MUL;
			ST_RS_DIV:   cmd.op = OP_RS_DIV;
			ST_RS_WAIT:  cmd.op = OP_RS_WAIT;
			ST_ROT_INIT: cmd.op = OP_ROT_INIT;
			ST_CORDIC:   cmd.op = OP_CORDIC;
			ST_FIN_X:    cmd.op = OP_FIN_X;
			ST_FIN_Y:    cmd.op = OP_FIN_Y;
			ST_FIN_OUT:  cmd.op = out_free ? OP_FIN_OUT : OP_NONE;
			default:     cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_IDLE) begin
				axis_q <= 1'b0;
			end else if (state_q == ST_PID_OUT) begin
				axis_q <= !axis_q;
			end else if (state_q == ST_CMP) begin
				axis_q <= 1'b0;
				cnt_q  <= CNT_W'(30);
			end else if (state_q == ST_SQRT && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (state_q == ST_RS_WAIT && sts.div_done) begin
				axis_q <= 1'b1;
			end else if (state_q == ST_ROT_INIT) begin
				cnt_q <= '0;
			end else if (state_q == ST_CORDIC) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ST_FIN_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/two_axis_pid_velocity_controller_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Two-axis PID velocity controller core
// Per-axis PID with feedforward, speed limiting and rotation by heading.
// ----------------------------------------------------------------------------
// The block takes one request at a time: it stalls its input from the cycle
// after a request is taken until the result has been loaded into the output
// register. A request's time is set by the shared one-bit-per-cycle divider
// (for each axis's derivative and, when the speed limit acts, for each rescale
// component), the 31-step square root when the limit acts, the 20-step CORDIC
// rotation and the halving steps for very large outputs. The result waits in
// its own register, so the next request is taken while the previous result is
// still stalled at the output.
// Configuration writes go to the register selected by cfg_idx and must happen
// only while the block is idle; indexes past the last register are ignored.
// A request with clear_loop set zeroes both integrators and stored errors
// before it is processed.
module two_axis_pid_velocity_controller_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire tapvc_pkg::in_req_t               in_req,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output tapvc_pkg::out_req_t                   out_req,
	input  wire logic                             cfg_we,
	input  wire logic [tapvc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [tapvc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tapvc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The sequencer decides what the datapath does in each cycle.
	tapvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the configuration, the loop state and the output register.
	tapvc_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_req   (in_req),
		.cmd      (cmd),
		.sts      (sts),
		.out_req  (out_req)
	);

endmodule
`default_nettype wire
